// ===== design/sfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfbp_pkg
// Shared types and constants of the serial receive FIFO bus port.
// ----------------------------------------------------------------------------
package sfbp_pkg;

	// Default ring depth; the ring holds at most one entry less than this.
	localparam int unsigned FIFO_DEPTH_DEF = 256;

	// Depth of the queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Item kinds as they arrive on tuser.
	typedef enum logic [1:0] {
		MODE_RX   = 2'd0,
		MODE_POP  = 2'd1,
		MODE_STAT = 2'd2,
		MODE_HOST = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_HOST_TO_PRI = 2'd0,
		CFG_HOST_TO_SEC = 2'd1,
		CFG_RX_TO_PRI   = 2'd2,
		CFG_RX_TO_SEC   = 2'd3
	} cfg_idx_t;

	// Routing switches.
	typedef struct packed {
		logic host_to_primary_tx;
		logic host_to_secondary_tx;
		logic rx_to_primary_tx;
		logic rx_to_secondary_tx;
	} cfg_t;

	// A classified item as it waits in the queue.
	typedef struct packed {
		logic       is_rx;
		logic       is_pop;
		logic       is_stat;
		logic       is_host;
		logic [7:0] data;
	} item_t;

	// Result fields; the last member lands in the lowest bits.
	typedef struct packed {
		logic       dropped;
		logic [7:0] tx_byte;
		logic       secondary_tx_valid;
		logic       primary_tx_valid;
		logic [7:0] read_value;
		logic       read_valid;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== design/sfbp_front.sv =====
// ----------------------------------------------------------------------------
// sfbp_front
// Accepts items, decodes their kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module sfbp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] byte_in
	input  logic [1:0]    s_tuser,   // [1:0] mode
	output logic          q_valid,
	output sfbp_pkg::item_t q_item,
	input  logic          q_take
);
	import sfbp_pkg::*;

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              slot_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]   wr_q;
	logic [IDX_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;
	item_t              item_d;
	logic               push;
	logic               pop;

	// Decode the kind of the incoming item.
	always_comb begin
		item_d      = '0;
		item_d.data = s_tdata;
		unique case (mode_t'(s_tuser))
			MODE_RX:   item_d.is_rx   = 1'b1;
			MODE_POP:  item_d.is_pop  = 1'b1;
			MODE_STAT: item_d.is_stat = 1'b1;
			MODE_HOST: item_d.is_host = 1'b1;
		endcase
	end

	assign s_tready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = slot_q[rd_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_take && q_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item_d;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/sfbp_back.sv =====
// ----------------------------------------------------------------------------
// sfbp_back
// Carries out queued items on the ring FIFO and drives the result register.
// ----------------------------------------------------------------------------
module sfbp_back #(
	parameter int unsigned FIFO_DEPTH = sfbp_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  sfbp_pkg::item_t   q_item,
	output logic              q_take,
	input  sfbp_pkg::cfg_t    cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output sfbp_pkg::result_t out_res
);
	import sfbp_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_RDWAIT
	} state_t;

	state_t           state_q;
	logic [7:0]       mem [FIFO_DEPTH];
	logic [7:0]       rdata_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             out_valid_q;
	result_t          out_q;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;
	logic             empty;
	logic             full;
	logic             mem_we;
	logic             mem_re;
	result_t          res_d;
	result_t          res_rd;
	logic             pri_d;
	logic             sec_d;

	// Ring status.
	assign wr_next = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_next == rd_ptr_q);

	// Take an item when idle and the output register is free or being emptied.
	assign q_take = (state_q == ST_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign mem_we = q_take && q_item.is_rx && !full;
	assign mem_re = q_take && q_item.is_pop && !empty;

	// Result of an item that needs no ring read.
	always_comb begin
		pri_d = (q_item.is_rx && cfg.rx_to_primary_tx) ||
			(q_item.is_host && cfg.host_to_primary_tx);
		sec_d = (q_item.is_rx && cfg.rx_to_secondary_tx) ||
			(q_item.is_host && cfg.host_to_secondary_tx);
		res_d                    = '0;
		res_d.read_valid         = q_item.is_pop || q_item.is_stat;
		res_d.read_value         = {7'd0, q_item.is_stat && !empty};
		res_d.primary_tx_valid   = pri_d;
		res_d.secondary_tx_valid = sec_d;
		res_d.tx_byte            = (pri_d || sec_d) ? q_item.data : 8'd0;
		res_d.dropped            = q_item.is_rx && full;
	end

	// Result of a data read that popped a byte from the ring.
	always_comb begin
		res_rd            = '0;
		res_rd.read_valid = 1'b1;
		res_rd.read_value = rdata_q;
	end

	// Ring storage with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= q_item.data;
		end
		if (mem_re) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	// Sequencer, pointers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (mem_we) begin
				wr_ptr_q <= wr_next;
			end
			if (mem_re) begin
				rd_ptr_q <= rd_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (mem_re) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_RDWAIT;
					end else if (q_take) begin
						out_valid_q <= 1'b1;
						out_q       <= res_d;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_RDWAIT: begin
					out_valid_q <= 1'b1;
					out_q       <= res_rd;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== design/serial_rx_fifo_bus_port.sv =====
// ----------------------------------------------------------------------------
// serial_rx_fifo_bus_port
// Serial receive FIFO with a host bus port and two routed transmit links.
// ----------------------------------------------------------------------------
// m_tvalid of a result rises once its item has left the front queue and its result
// is registered; a data read that pops a byte first waits in ST_RDWAIT on the ring.
// Throughput: one item per cycle while the output is not stalled; a popping data
// read holds the back part in ST_RDWAIT, taking no new item until its result is
// registered.
// Reset clears the ring pointers, the queue, the routing switches and the
// output register at once; the ring contents are not cleared.
module serial_rx_fifo_bus_port #(
	parameter int unsigned FIFO_DEPTH = sfbp_pkg::FIFO_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] byte_in
	input  logic [1:0]                       s_tuser,  // [1:0] mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] read_valid, [8:1] read_value, [9] primary_tx_valid,
	// [10] secondary_tx_valid, [18:11] tx_byte, [19] dropped, zero above
	output logic [sfbp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic                             cfg_data
);
	import sfbp_pkg::*;

	cfg_t    cfg_q;
	item_t   q_item;
	logic    q_valid;
	logic    q_take;
	result_t res;

	// Routing switch registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HOST_TO_PRI: cfg_q.host_to_primary_tx   <= cfg_data;
				CFG_HOST_TO_SEC: cfg_q.host_to_secondary_tx <= cfg_data;
				CFG_RX_TO_PRI:   cfg_q.rx_to_primary_tx     <= cfg_data;
				CFG_RX_TO_SEC:   cfg_q.rx_to_secondary_tx   <= cfg_data;
			endcase
		end
	end

	// Front part: accept and classify.
	sfbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_take   (q_take)
	);

	// Back part: ring FIFO and result register.
	sfbp_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res};

endmodule

// ===== design/sfbp_checker.sv =====
// ----------------------------------------------------------------------------
// sfbp_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sfbp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sfbp_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sfbp_pkg::*;

	// A stalled result stays and holds its fields.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A read result never also sends a byte.
	a_read_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[9] && !m_tdata[10])
		else $error("read result flags a transmitter");

	// Only a received byte can be dropped, and a read never is one.
	a_drop_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19] |-> !m_tdata[0] && (m_tdata[8:1] == 8'd0))
		else $error("dropped flag on a read result");

	// With no transmitter flagged the sent byte is zero.
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] && !m_tdata[10] |-> (m_tdata[18:11] == 8'd0))
		else $error("tx byte set with no transmitter flagged");

endmodule

bind serial_rx_fifo_bus_port sfbp_checker u_sfbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/serial_rx_fifo_bus_port_tb.sv =====
// ----------------------------------------------------------------------------
// serial_rx_fifo_bus_port_tb
// Self-checking bench for the serial receive FIFO bus port. Received bytes,
// host data and status reads and host writes are sent on the input stream.
// A local ring model predicts every result item. The output stream is compared
// field by field, under random sender gaps, receiver stalls and one long
// receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module serial_rx_fifo_bus_port_tb;
	import sfbp_pkg::*;

	localparam int unsigned RING_DEPTH   = FIFO_DEPTH_DEF;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned PHASE_ITEMS  = 60;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;
	logic [1:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic                   cfg_data  = 1'b0;

	// Local copy of the ring, its pointers and the routing switches.
	logic [7:0]  ring [RING_DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned rd_ptr = 0;
	cfg_t        routing = '0;

	// Results still owed by the block, oldest first.
	result_t     pending_results [$];
	int unsigned error_count = 0;

	// Sender pacing.
	bit          gaps_on = 1'b0;
	int unsigned burst_left = 0;

	// Receiver pacing.
	bit          stalls_on = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	logic [15:0] ready_pattern = '1;
	int unsigned pattern_pos = 0;

	int unsigned idle_cycles = 0;

	serial_rx_fifo_bus_port #(
		.FIFO_DEPTH(RING_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Work out the result of one item and advance the local ring.
	function automatic result_t ring_port_result(input mode_t mode, input logic [7:0] data);
		result_t     r;
		int unsigned nxt;
		r = '0;
		case (mode)
			MODE_RX: begin
				nxt = (wr_ptr + 1) % RING_DEPTH;
				r.primary_tx_valid   = routing.rx_to_primary_tx;
				r.secondary_tx_valid = routing.rx_to_secondary_tx;
				if (nxt != rd_ptr) begin
					ring[wr_ptr] = data;
					wr_ptr = nxt;
				end else begin
					r.dropped = 1'b1;
				end
			end
			MODE_POP: begin
				r.read_valid = 1'b1;
				if (rd_ptr != wr_ptr) begin
					r.read_value = ring[rd_ptr];
					rd_ptr = (rd_ptr + 1) % RING_DEPTH;
				end
			end
			MODE_STAT: begin
				r.read_valid = 1'b1;
				r.read_value = {7'd0, rd_ptr != wr_ptr};
			end
			default: begin
				r.primary_tx_valid   = routing.host_to_primary_tx;
				r.secondary_tx_valid = routing.host_to_secondary_tx;
			end
		endcase
		// The transmit byte is only meaningful when some link is flagged.
		if (r.primary_tx_valid || r.secondary_tx_valid)
			r.tx_byte = data;
		return r;
	endfunction

	// Send one item, opening a new burst, after a random gap if gaps are on, when the last one ran out.
	task automatic send_item(input mode_t mode, input logic [7:0] data);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(16, 1);
			if (gaps_on) begin
				gap = $urandom_range(6, 1);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(ring_port_result(mode, data));
	endtask

	// Stop sending and let every owed result drain out of the block.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four routing switches while the block is idle.
	task automatic set_routing(input cfg_t r);
		cfg_idx_t idx;
		wait_idle();
		idx = idx.first();
		repeat (4) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			case (idx)
				CFG_HOST_TO_PRI: cfg_data <= r.host_to_primary_tx;
				CFG_HOST_TO_SEC: cfg_data <= r.host_to_secondary_tx;
				CFG_RX_TO_PRI:   cfg_data <= r.rx_to_primary_tx;
				default:         cfg_data <= r.rx_to_secondary_tx;
			endcase
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we  <= 1'b0;
		routing = r;
	endtask

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// Compare one output item with the oldest owed result.
	task automatic check_output(input logic [OUT_TDATA_W-1:0] word);
		result_t got;
		result_t want;
		got = result_t'(word[RESULT_W-1:0]);
		if (pending_results.size() == 0) begin
			$error("result item %0h arrived with none owed", word);
			error_count++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
		compare_field("read_value", 32'(want.read_value), 32'(got.read_value));
		compare_field("primary_tx_valid", 32'(want.primary_tx_valid),
			32'(got.primary_tx_valid));
		compare_field("secondary_tx_valid", 32'(want.secondary_tx_valid),
			32'(got.secondary_tx_valid));
		compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
		compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
		compare_field("padding", 32'd0, 32'(word >> RESULT_W));
	endtask

	// Receiver: check each accepted item, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_output(m_tdata);
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (!stalls_on) begin
				m_tready <= 1'b1;
			end else begin
				if (pattern_pos == 0) begin
					ready_pattern = 16'($urandom());
					if ($urandom_range(1, 0))
						ready_pattern = ready_pattern | 16'($urandom());
				end
				m_tready <= ready_pattern[pattern_pos];
				pattern_pos = (pattern_pos + 1) % 16;
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Field extremes, every item kind, empty reads and four routing settings.
	task automatic test_directed();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		set_routing('0);
		send_item(MODE_STAT, 8'h00);
		send_item(MODE_POP,  8'hFF);
		send_item(MODE_HOST, 8'hFF);
		send_item(MODE_RX,   8'h00);
		send_item(MODE_RX,   8'hFF);
		send_item(MODE_STAT, 8'h55);
		send_item(MODE_POP,  8'h00);
		send_item(MODE_POP,  8'h00);
		send_item(MODE_POP,  8'h00);
		send_item(MODE_STAT, 8'h00);
		set_routing('{1'b1, 1'b1, 1'b1, 1'b1});
		send_item(MODE_RX,   8'hA5);
		send_item(MODE_HOST, 8'h5A);
		send_item(MODE_HOST, 8'h00);
		send_item(MODE_POP,  8'h00);
		set_routing('{1'b1, 1'b0, 1'b1, 1'b0});
		send_item(MODE_RX,   8'h81);
		send_item(MODE_HOST, 8'h7E);
		set_routing('{1'b0, 1'b1, 1'b0, 1'b1});
		send_item(MODE_RX,   8'h3C);
		send_item(MODE_HOST, 8'hC3);
		send_item(MODE_POP,  8'h00);
		send_item(MODE_POP,  8'h00);
	endtask

	// Fill the ring to its limit, overflow it, then drain it past empty.
	task automatic test_fill_and_drain();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		set_routing('{1'b0, 1'b0, 1'b1, 1'b1});
		repeat (RING_DEPTH - 1) send_item(MODE_RX, 8'($urandom()));
		repeat (4) send_item(MODE_RX, 8'($urandom()));
		send_item(MODE_STAT, 8'($urandom()));
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (RING_DEPTH + 1) send_item(MODE_POP, 8'($urandom()));
		send_item(MODE_STAT, 8'($urandom()));
	endtask

	// Hold the receiver off while the sender keeps offering items.
	task automatic test_backpressure();
		set_routing('{1'b1, 1'b0, 1'b0, 1'b1});
		gaps_on      = 1'b0;
		stalls_on    = 1'b0;
		hold_request = 1'b1;
		repeat (8) send_item(MODE_RX, 8'($urandom()));
		repeat (8) send_item(MODE_POP, 8'($urandom()));
		repeat (4) send_item(MODE_HOST, 8'($urandom()));
		repeat (4) send_item(MODE_STAT, 8'($urandom()));
	endtask

	// Random traffic in phases with differing routing and fill pressure.
	task automatic test_random_traffic();
		cfg_t        r;
		int unsigned rx_weight;
		int unsigned pick;
		mode_t       mode;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       r = '0;
				1:       r = '1;
				default: r = cfg_t'(4'($urandom()));
			endcase
			set_routing(r);
			gaps_on   = 1'($urandom_range(1, 0));
			stalls_on = 1'($urandom_range(1, 0));
			rx_weight = $urandom_range(75, 20);
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(99, 0);
				if (pick < rx_weight)
					mode = MODE_RX;
				else if (pick < rx_weight + (100 - rx_weight) / 2)
					mode = MODE_POP;
				else if ($urandom_range(1, 0))
					mode = MODE_STAT;
				else
					mode = MODE_HOST;
				send_item(mode, 8'($urandom()));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
